[sv/tle_pkg.sv]
// shared types, codes and tree sizing functions for the text line buffer editor
`default_nettype none

package tle_pkg;

  localparam int TLE_CAPACITY = 1024;
  localparam int TLE_POS_W    = 10;
  localparam int TLE_RADIX    = 32;

  localparam logic [2:0] KIND_INSERT    = 3'd0;
  localparam logic [2:0] KIND_BACKSPACE = 3'd1;
  localparam logic [2:0] KIND_LEFT      = 3'd2;
  localparam logic [2:0] KIND_RIGHT     = 3'd3;
  localparam logic [2:0] KIND_READ      = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EDGE  = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE
  } shift_op_t;

  typedef struct packed {
    shift_op_t  op;
    logic [7:0] data;
  } shift_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  // node count of tree level k over n leaves
  function automatic int tle_lvl_size(int n, int k);
    int s;
    s = n;
    for (int i = 0; i < k; i++) s = (s + TLE_RADIX - 1) / TLE_RADIX;
    return s;
  endfunction

  // number of registered levels needed to reduce n leaves to one node
  function automatic int tle_levels(int n);
    int s;
    int l;
    s = n;
    l = 0;
    for (int i = 0; i < 32; i++) begin
      if (s > 1 || l == 0) begin
        s = (s + TLE_RADIX - 1) / TLE_RADIX;
        l = l + 1;
      end
    end
    return l;
  endfunction

  // offset of level k (k >= 1) in the flat node array
  function automatic int tle_lvl_off(int n, int k);
    int o;
    o = 0;
    for (int i = 1; i < k; i++) o = o + tle_lvl_size(n, i);
    return o;
  endfunction

endpackage

`default_nettype wire

[sv/tle_in_if.sv]
// request channel interface: edit kind, byte and read index
`default_nettype none

interface tle_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] char_byte;
  logic [9:0] read_index;

  modport source (output valid, output kind, output char_byte, output read_index,
                  input ready);
  modport sink   (input valid, input kind, input char_byte, input read_index,
                  output ready);
endinterface

`default_nettype wire

[sv/tle_out_if.sv]
// result channel interface: status, cursor, length and read byte
`default_nettype none

interface tle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [9:0] cursor_pos;
  logic [9:0] text_length;
  logic [7:0] read_byte;

  modport source (output valid, output status, output cursor_pos, output text_length,
                  output read_byte, input ready);
  modport sink   (input valid, input status, input cursor_pos, input text_length,
                  input read_byte, output ready);
endinterface

`default_nettype wire

[sv/tle_cell.sv]
// one byte cell of the text row, shifts with its neighbors on insert and delete
`default_nettype none

module tle_cell #(
  parameter int AW  = 10,
  parameter int IDX = 0
) (
  input  logic               clk,
  input  tle_pkg::shift_cmd_t cmd,
  input  logic [AW-1:0]      pos,
  input  logic [AW-1:0]      rd_idx,
  input  logic [7:0]         left_byte,
  input  logic [7:0]         right_byte,
  output logic [7:0]         data_o,
  output logic [7:0]         leaf_o
);
  import tle_pkg::*;

  localparam logic [AW-1:0] MY_IDX = AW'(IDX);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      OP_HOLD: begin
        data_nxt = data_r;
      end
      OP_INSERT: begin
        // cells above the cursor take from below, the cursor cell takes the new byte
        if (MY_IDX > pos) begin
          data_nxt = left_byte;
        end else if (MY_IDX == pos) begin
          data_nxt = cmd.data;
        end
      end
      OP_DELETE: begin
        if (MY_IDX >= pos) begin
          data_nxt = right_byte;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign leaf_o = (MY_IDX == rd_idx) ? data_r : 8'h00;

endmodule

`default_nettype wire

[sv/tle_rd_tree.sv]
// registered or-reduction tree that collects the selected cell byte
`default_nettype none

module tle_rd_tree #(
  parameter int N = 1024
) (
  input  logic       clk,
  input  logic [7:0] leaf [N],
  output logic [7:0] top_o
);
  import tle_pkg::*;

  localparam int LEVELS = tle_levels(N);
  localparam int TOT    = tle_lvl_off(N, LEVELS + 1);

  logic [7:0] tree_r [TOT];

  for (genvar k = 1; k <= LEVELS; k++) begin : g_lvl
    localparam int SRC_N   = tle_lvl_size(N, k - 1);
    localparam int DST_N   = tle_lvl_size(N, k);
    localparam int SRC_OFF = tle_lvl_off(N, k - 1);
    localparam int DST_OFF = tle_lvl_off(N, k);

    for (genvar j = 0; j < DST_N; j++) begin : g_node
      localparam int BASE = j * TLE_RADIX;
      localparam int CNT  = (SRC_N - BASE < TLE_RADIX) ? (SRC_N - BASE) : TLE_RADIX;

      logic [7:0] acc_nxt;

      if (k == 1) begin : g_leaf
        always_comb begin
          acc_nxt = 8'h00;
          for (int i = 0; i < CNT; i++) acc_nxt = acc_nxt | leaf[BASE + i];
        end
      end else begin : g_inner
        always_comb begin
          acc_nxt = 8'h00;
          for (int i = 0; i < CNT; i++) acc_nxt = acc_nxt | tree_r[SRC_OFF + BASE + i];
        end
      end

      always_ff @(posedge clk) begin
        tree_r[DST_OFF + j] <= acc_nxt;
      end
    end
  end

  assign top_o = tree_r[TOT - 1];

endmodule

`default_nettype wire

[sv/text_line_buffer_editor.sv]
// text line buffer editor: insert, backspace, cursor moves and reads on a row of byte cells
//
// in_chan takes one request at a time (valid/ready); out_chan returns exactly one
// result per request through an output register (valid/ready).
// The text lives in a row of CAPACITY byte cells. An insert or backspace moves every
// cell after the cursor by one place in the edge the request is accepted.
// Insert, backspace, left, right and out-of-range reads go from acceptance through the
// run state straight into the output register.
// An in-range read goes through a registered or-tree of radix 32 over the cells,
// ceil(log32(CAPACITY)) levels (2 at 1024); the run state waits for those levels
// to fill before the read byte is loaded into the output register.
// The next request is taken once the current one has moved into the output register,
// even while that result still waits for out_chan.ready.
// A stalled receiver holds the result; the following request then waits in the
// run state and in_chan.ready stays low until the output register frees up.
// Synchronous reset clears cursor, length and the handshake state; the text is
// empty after reset and cell contents are not cleared.
`default_nettype none

module text_line_buffer_editor #(
  parameter int CAPACITY = tle_pkg::TLE_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  tle_in_if.sink    in_chan,
  tle_out_if.source out_chan
);
  import tle_pkg::*;

  localparam int AW     = $clog2(CAPACITY);
  localparam int CW     = (AW > TLE_POS_W) ? AW : TLE_POS_W;
  localparam int LEVELS = tle_levels(CAPACITY);
  localparam int CNT_W  = $clog2(LEVELS + 1);
  localparam logic [AW-1:0] CAP_M1 = AW'(CAPACITY - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    cursor_r, cursor_nxt;
  logic [AW-1:0]    length_r, length_nxt;
  logic [1:0]       stat_r, stat_nxt;
  logic             rd_ok_r, rd_ok_nxt;
  logic [AW-1:0]    rd_idx_r, rd_idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r;
  logic [9:0]       out_cursor_r;
  logic [9:0]       out_length_r;
  logic [7:0]       out_rbyte_r;

  logic             in_acc;
  logic             load_out;
  shift_cmd_t       cmd;
  logic [AW-1:0]    pos;
  logic [CW-1:0]    idx_ext;
  logic [CW-1:0]    length_ext;
  logic [CW-1:0]    cursor_ext;
  logic [7:0]       tree_top;

  logic [7:0] cell_data [CAPACITY];
  logic [7:0] cell_leaf [CAPACITY];

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign idx_ext       = CW'(in_chan.read_index);
  assign length_ext    = CW'(length_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cursor_nxt    = cursor_r;
    length_nxt    = length_r;
    stat_nxt      = stat_r;
    rd_ok_nxt     = rd_ok_r;
    rd_idx_nxt    = rd_idx_r;
    cmd.op        = OP_HOLD;
    cmd.data      = in_chan.char_byte;
    pos           = cursor_r;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RUN;
          cnt_nxt   = '0;
          rd_ok_nxt = 1'b0;
          stat_nxt  = STAT_EDGE;
          unique case (in_chan.kind)
            KIND_INSERT: begin
              if (length_r >= CAP_M1) begin
                stat_nxt = STAT_FULL;
              end else begin
                cmd.op     = OP_INSERT;
                cursor_nxt = cursor_r + 1'b1;
                length_nxt = length_r + 1'b1;
                stat_nxt   = STAT_OK;
              end
            end
            KIND_BACKSPACE: begin
              if (cursor_r != '0) begin
                // remove the byte just below the cursor
                cmd.op     = OP_DELETE;
                pos        = cursor_r - 1'b1;
                cursor_nxt = cursor_r - 1'b1;
                length_nxt = length_r - 1'b1;
                stat_nxt   = STAT_OK;
              end
            end
            KIND_LEFT: begin
              if (cursor_r != '0) begin
                cursor_nxt = cursor_r - 1'b1;
                stat_nxt   = STAT_OK;
              end
            end
            KIND_RIGHT: begin
              if (cursor_r < length_r) begin
                cursor_nxt = cursor_r + 1'b1;
                stat_nxt   = STAT_OK;
              end
            end
            KIND_READ: begin
              if (idx_ext < length_ext) begin
                rd_ok_nxt  = 1'b1;
                rd_idx_nxt = idx_ext[AW-1:0];
                cnt_nxt    = CNT_W'(LEVELS);
                stat_nxt   = STAT_OK;
              end else begin
                stat_nxt = STAT_RANGE;
              end
            end
            default: begin
              stat_nxt = STAT_EDGE;
            end
          endcase
        end
      end
      S_RUN: begin
        // wait for the read tree, then hand over once the output register is free
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end else if (!out_valid_r || out_chan.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cursor_r    <= '0;
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cursor_r    <= cursor_nxt;
      length_r    <= length_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cursor_ext = CW'(cursor_r);

  always_ff @(posedge clk) begin
    stat_r   <= stat_nxt;
    rd_ok_r  <= rd_ok_nxt;
    rd_idx_r <= rd_idx_nxt;
    if (load_out) begin
      out_status_r <= stat_r;
      out_cursor_r <= cursor_ext[TLE_POS_W-1:0];
      out_length_r <= length_ext[TLE_POS_W-1:0];
      out_rbyte_r  <= rd_ok_r ? tree_top : 8'h00;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [7:0] left_b;
    logic [7:0] right_b;

    if (i == 0) begin : g_first
      assign left_b = 8'h00;
    end else begin : g_mid_l
      assign left_b = cell_data[i - 1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_b = 8'h00;
    end else begin : g_mid_r
      assign right_b = cell_data[i + 1];
    end

    tle_cell #(
      .AW  (AW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos),
      .rd_idx     (rd_idx_r),
      .left_byte  (left_b),
      .right_byte (right_b),
      .data_o     (cell_data[i]),
      .leaf_o     (cell_leaf[i])
    );
  end

  tle_rd_tree #(
    .N (CAPACITY)
  ) u_rd_tree (
    .clk   (clk),
    .leaf  (cell_leaf),
    .top_o (tree_top)
  );

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.cursor_pos  = out_cursor_r;
  assign out_chan.text_length = out_length_r;
  assign out_chan.read_byte   = out_rbyte_r;

`ifndef SYNTHESIS
  a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= length_r)
    else $error("cursor beyond text length");

  a_length_step: assert property (@(posedge clk) disable iff (!rst_n)
    (length_r == $past(length_r)) || (length_r == $past(length_r) + 1'b1) ||
    (length_r == $past(length_r) - 1'b1))
    else $error("text length moved by more than one");

  a_request_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_RUN))
    else $error("accepted request did not start");

  a_length_cap: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= CAP_M1)
    else $error("text length above capacity limit");
`endif

endmodule

`default_nettype wire
